// ===== rtl/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants of the terminal line editor
// Byte codes, status codes, register indexes and the per-cell edit command.
// ----------------------------------------------------------------------------
package tle_pkg;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 7;
  localparam int POS_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // default line store depth
  localparam int DEF_LINE_CAPACITY = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_CODE = 1'd1;

  // register reset values
  localparam logic [LEN_W-1:0]  RESET_LINE_LIMIT = 7'd64;
  localparam logic [BYTE_W-1:0] RESET_ERASE_CODE = 8'd127;

  // byte codes
  localparam logic [BYTE_W-1:0] KEY_LF       = 8'd10;
  localparam logic [BYTE_W-1:0] KEY_CR       = 8'd13;
  localparam logic [BYTE_W-1:0] KEY_ESC      = 8'd27;
  localparam logic [BYTE_W-1:0] KEY_LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] KEY_RIGHT    = 8'h43;
  localparam logic [BYTE_W-1:0] KEY_LEFT     = 8'h44;
  localparam logic [BYTE_W-1:0] KEY_DELETE   = 8'h33;
  localparam logic [BYTE_W-1:0] PRINT_LO     = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI     = 8'd126;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_LINE   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPLIED = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_PENDING = 2'd3
  } edit_status_t;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_OPEN,
    ESC_BRACKET,
    ESC_DELETE
  } esc_stage_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_FLUSH
  } ctl_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SHIFT
  } cell_op_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t              op;
    logic [POS_W-1:0]      pos;
    logic [BYTE_W-1:0]     ch;
  } cell_ctrl_t;

endpackage

// ===== rtl/tle_in_if.sv =====
// ----------------------------------------------------------------------------
// tle_in_if: received byte channel
// Valid/ready channel carrying one serial byte per beat.
// ----------------------------------------------------------------------------
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/tle_out_if.sv =====
// ----------------------------------------------------------------------------
// tle_out_if: editor result channel
// Valid/ready channel carrying one edit status or one line byte per beat.
// ----------------------------------------------------------------------------
interface tle_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] line_byte;
  logic [6:0] cursor_pos;
  logic [6:0] line_length;
  logic       last;
  logic [1:0] edit_status;

  modport source (output valid, output result_kind, output line_byte,
                  output cursor_pos, output line_length, output last,
                  output edit_status, input ready);
  modport sink   (input valid, input result_kind, input line_byte,
                  input cursor_pos, input line_length, input last,
                  input edit_status, output ready);
endinterface

// ===== rtl/terminal_line_editor_unit.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor_unit: editable line with cursor over a serial byte feed
// Inserts, erases, moves the cursor on ANSI arrow keys and flushes the line
// byte by byte on CR or LF.
//
//   channel  modport  beat
//   rx       sink     one received byte
//   res      source   one edit status or one byte of a completed line
//   cfg      write    line_limit (index 0), erase_code (index 1)
//
// A byte that causes a status result is accepted and its result lands in the
// output register at the same edge.
// CR or LF on a non-empty line is accepted, then the cell chain shifts the
// line out through cell 0, one character per cycle unless res stalls.
// rx is not ready while the output register is held by an untaken result
// or while a line is flushing; res stalls simply freeze the flush.
// Reset clears cursor, fill, escape state and the output valid; the cells
// need no clearing.
// ----------------------------------------------------------------------------
module terminal_line_editor_unit #(
  parameter int LINE_CAPACITY = tle_pkg::DEF_LINE_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  tle_in_if.sink                           rx,
  tle_out_if.source                        res,
  input  logic                             cfg_we,
  input  logic [tle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tle_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tle_pkg::*;

  localparam int PW = $clog2(LINE_CAPACITY + 1);

  // configuration
  logic [LEN_W-1:0]  line_limit;
  logic [BYTE_W-1:0] erase_code;

  // editor state
  logic [PW-1:0] cursor, cursor_next;
  logic [PW-1:0] fill, fill_next;
  esc_stage_t    esc, esc_next;
  logic          mismatch, mismatch_next;
  ctl_state_t    state, state_next;
  logic [PW-1:0] flush_idx, flush_len;

  // output register
  logic              out_valid;
  logic              out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  out_cursor;
  logic [LEN_W-1:0]  out_length;
  logic              out_last;
  edit_status_t      out_status;

  // decode results
  edit_status_t  status;
  cell_ctrl_t    edit_ctrl, ctrl;
  logic          go_flush;
  logic [LEN_W-1:0] limit_use;

  logic              out_free, in_fire, flush_step, flush_last;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] head_ch;

  assign b          = rx.rx_byte;
  assign out_free   = !out_valid || res.ready;
  assign in_fire    = rx.valid && rx.ready;
  assign flush_last = (flush_idx + PW'(1)) == flush_len;
  assign limit_use  = (line_limit > LEN_W'(LINE_CAPACITY)) ? LEN_W'(LINE_CAPACITY)
                                                          : line_limit;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= RESET_LINE_LIMIT;
      erase_code <= RESET_ERASE_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_LIMIT: line_limit <= cfg_wdata[LEN_W-1:0];
        REG_ERASE_CODE: erase_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // byte decode: next editor state, status and cell command
  always_comb begin
    cursor_next    = cursor;
    fill_next      = fill;
    esc_next       = esc;
    mismatch_next  = mismatch;
    status         = ST_IGNORED;
    go_flush       = 1'b0;
    edit_ctrl.op   = CELL_HOLD;
    edit_ctrl.pos  = POS_W'(cursor);
    edit_ctrl.ch   = b;
    case (esc)
      ESC_OPEN: begin
        mismatch_next = (b != KEY_LBRACKET);
        esc_next      = ESC_BRACKET;
        status        = ST_PENDING;
      end
      ESC_BRACKET: begin
        esc_next      = ESC_NONE;
        mismatch_next = 1'b0;
        if (!mismatch) begin
          if (b == KEY_RIGHT) begin
            if (cursor < fill) begin
              cursor_next = cursor + PW'(1);
              status      = ST_APPLIED;
            end
          end else if (b == KEY_LEFT) begin
            if (cursor != '0) begin
              cursor_next = cursor - PW'(1);
              status      = ST_APPLIED;
            end
          end else if (b == KEY_DELETE) begin
            esc_next = ESC_DELETE;
            status   = ST_PENDING;
          end
        end
      end
      ESC_DELETE: begin
        esc_next = ESC_NONE;
        if (cursor < fill) begin
          edit_ctrl.op = CELL_REMOVE;
          fill_next    = fill - PW'(1);
          status       = ST_APPLIED;
        end
      end
      default: begin
        if (b == erase_code) begin
          if (cursor != '0) begin
            cursor_next   = cursor - PW'(1);
            edit_ctrl.op  = CELL_REMOVE;
            edit_ctrl.pos = POS_W'(cursor - PW'(1));
            fill_next     = fill - PW'(1);
            status        = ST_APPLIED;
          end
        end else if (b inside {KEY_CR, KEY_LF}) begin
          cursor_next = '0;
          fill_next   = '0;
          status      = ST_APPLIED;
          go_flush    = (fill != '0);
        end else if (b == KEY_ESC) begin
          esc_next      = ESC_OPEN;
          mismatch_next = 1'b0;
          status        = ST_PENDING;
        end else if (b inside {[PRINT_LO:PRINT_HI]}) begin
          if (LEN_W'(fill) >= limit_use) begin
            status = ST_FULL;
          end else begin
            edit_ctrl.op = CELL_INSERT;
            cursor_next  = cursor + PW'(1);
            fill_next    = fill + PW'(1);
            status       = ST_APPLIED;
          end
        end
      end
    endcase
  end

  // control state machine: next state
  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE:  if (in_fire && go_flush) state_next = CTL_FLUSH;
      CTL_FLUSH: if (flush_step && flush_last) state_next = CTL_IDLE;
      default:   state_next = CTL_IDLE;
    endcase
  end

  // control state machine: outputs
  always_comb begin
    rx.ready   = 1'b0;
    flush_step = 1'b0;
    ctrl       = edit_ctrl;
    ctrl.op    = CELL_HOLD;
    case (state)
      CTL_IDLE: begin
        rx.ready = out_free;
        if (in_fire) ctrl = edit_ctrl;
      end
      CTL_FLUSH: begin
        flush_step = out_free;
        if (out_free) ctrl.op = CELL_SHIFT;
      end
      default: ;
    endcase
  end

  // editor and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CTL_IDLE;
      cursor   <= '0;
      fill     <= '0;
      esc      <= ESC_NONE;
      mismatch <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        cursor   <= cursor_next;
        fill     <= fill_next;
        esc      <= esc_next;
        mismatch <= mismatch_next;
      end
    end
  end

  // flush position and length
  always_ff @(posedge clk) begin
    if (in_fire && go_flush) begin
      flush_idx <= '0;
      flush_len <= fill;
    end else if (flush_step) begin
      flush_idx <= flush_idx + PW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (flush_step || (in_fire && !go_flush)) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flush_step) begin
      out_kind   <= KIND_LINE;
      out_byte   <= head_ch;
      out_cursor <= '0;
      out_length <= LEN_W'(flush_len);
      out_last   <= flush_last;
      out_status <= ST_APPLIED;
    end else if (in_fire && !go_flush) begin
      out_kind   <= KIND_STATUS;
      out_byte   <= '0;
      out_cursor <= LEN_W'(cursor_next);
      out_length <= LEN_W'(fill_next);
      out_last   <= 1'b1;
      out_status <= status;
    end
  end

  assign res.valid       = out_valid;
  assign res.result_kind = out_kind;
  assign res.line_byte   = out_byte;
  assign res.cursor_pos  = out_cursor;
  assign res.line_length = out_length;
  assign res.last        = out_last;
  assign res.edit_status = out_status;

  // character cells
  tle_chain #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .head_ch (head_ch)
  );

`ifndef ASSERT_OFF
  // cursor never runs past the end of the line
  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= fill) else $error("cursor beyond fill");

  // fill never exceeds the cell count
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= PW'(LINE_CAPACITY)) else $error("fill beyond capacity");

  // a flush always starts from a cleared line
  a_flush_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == CTL_FLUSH) |-> (fill == '0 && cursor == '0))
    else $error("line not cleared during flush");

  // the final line byte returns the controller to idle
  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    (flush_step && flush_last) |=> (state == CTL_IDLE && res.valid && res.last))
    else $error("flush did not end on last byte");
`endif

endmodule

// ===== rtl/tle_cell.sv =====
// ----------------------------------------------------------------------------
// tle_cell: one character position of the line
// Holds one byte; takes its left or right neighbour, or the new byte,
// as the broadcast command and its own position dictate.
// ----------------------------------------------------------------------------
module tle_cell (
  input  logic                          clk,
  input  tle_pkg::cell_ctrl_t           ctrl,
  input  logic [tle_pkg::POS_W-1:0]     idx,
  input  logic [tle_pkg::BYTE_W-1:0]    left_ch,
  input  logic [tle_pkg::BYTE_W-1:0]    right_ch,
  output logic [tle_pkg::BYTE_W-1:0]    ch
);
  import tle_pkg::*;

  logic [BYTE_W-1:0] ch_next;

  // neighbour selection
  always_comb begin
    ch_next = ch;
    case (ctrl.op)
      CELL_INSERT: begin
        if (idx == ctrl.pos) begin
          ch_next = ctrl.ch;
        end else if (idx > ctrl.pos) begin
          ch_next = left_ch;
        end
      end
      CELL_REMOVE: begin
        if (idx >= ctrl.pos) begin
          ch_next = right_ch;
        end
      end
      CELL_SHIFT: ch_next = right_ch;
      default:    ch_next = ch;
    endcase
  end

  // character register, no reset
  always_ff @(posedge clk) begin
    ch <= ch_next;
  end

endmodule

// ===== rtl/tle_chain.sv =====
// ----------------------------------------------------------------------------
// tle_chain: row of character cells
// Cell 0 is the start of the line; shifts run along neighbour links and a
// completed line leaves through cell 0.
// ----------------------------------------------------------------------------
module tle_chain #(
  parameter int LINE_CAPACITY = tle_pkg::DEF_LINE_CAPACITY
) (
  input  logic                        clk,
  input  tle_pkg::cell_ctrl_t         ctrl,
  output logic [tle_pkg::BYTE_W-1:0]  head_ch
);
  import tle_pkg::*;

  logic [BYTE_W-1:0] ch       [LINE_CAPACITY];
  logic [BYTE_W-1:0] left_ch  [LINE_CAPACITY];
  logic [BYTE_W-1:0] right_ch [LINE_CAPACITY];

  for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
    // neighbour links; the ends see the new byte and zero
    if (i == 0) begin : g_first
      assign left_ch[i] = ctrl.ch;
    end else begin : g_mid_l
      assign left_ch[i] = ch[i-1];
    end
    if (i == LINE_CAPACITY - 1) begin : g_final
      assign right_ch[i] = '0;
    end else begin : g_mid_r
      assign right_ch[i] = ch[i+1];
    end

    tle_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .idx      (POS_W'(i)),
      .left_ch  (left_ch[i]),
      .right_ch (right_ch[i]),
      .ch       (ch[i])
    );
  end

  assign head_ch = ch[0];

endmodule
